// File: hdl/inwf_pkg.sv
// ============================================================================
// Impulse noise window filter package
// Shared types, codes and default sizes for the filter block.
// ============================================================================
package inwf_pkg;

    // Default sizes of the line store.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_WINDOW_DEF = 5;

    // Fixed field widths.
    localparam int PIX_W   = 8;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 10;
    localparam int CFGW_W  = 11;
    localparam int CFGH_W  = 13;
    localparam int WIN_W   = 3;
    localparam int CFGD_W  = 13;
    localparam int CFGI_W  = 2;

    // Largest row count and the cap on the row width.
    localparam int MAX_HEIGHT = 4096;
    localparam int WIDTH_CAP  = 1024;

    // Results one pixel beat may release.
    localparam int MAX_RES = 4;

    // Impulse noise levels.
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

    // Shared divider: sum of up to 49 pixels by a count of up to 49.
    localparam int DIV_W  = 14;
    localparam int DIVS_W = 6;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 2;

    typedef enum logic [CFGI_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_WINDOW = 2'd2,
        CFG_MODE   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CFGW_W-1:0] width;
        logic [CFGH_W-1:0] height;
        logic [WIN_W-1:0]  win;
        logic              mode;
    } t_cfg;

    typedef struct packed {
        logic             is_flush;
        logic [PIX_W-1:0] pixel;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WMOD,
        S_CHECK,
        S_RMOD,
        S_RD,
        S_DRAIN,
        S_EVAL,
        S_MDIV,
        S_ADV,
        S_LOOK
    } t_state;

endpackage

// File: hdl/impulse_noise_window_filter_top.sv
// ============================================================================
// Impulse noise window filter
// Selective median or mean filter for salt and pepper noise on a gray stream.
// ============================================================================
// Pixels arrive in raster order, one per input beat, and land in a line store
// of MAX_WINDOW rows of MAX_WIDTH pixels held in a single-port memory. A pixel
// of value 0 or 255 leaves as the truncated mean or the median of its odd
// window with edges replicated; any other pixel leaves unchanged. The block
// works on one input beat at a time. The store write of a pixel beat waits on
// the 14-step shared divider, which maps the row to a line store slot. Each
// released output then needs a slot lookup, a scan of the n = window*window
// neighbors per pass, since the memory gives one neighbor per cycle, and a
// move to the result register: one scan for a pixel that passes, one scan and
// a divide for the mean, and eight scans for the median, which is found one
// bit per scan. A pixel beat releases up to four outputs and a flush beat at
// most one; an output waiting in the result register does not keep the next
// input beat from entering the two-entry queue in front of the sequencer. The
// line store needs no clearing after reset.
// ============================================================================
module impulse_noise_window_filter_top
    import inwf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFGI_W-1:0] i_cfg_index,
    input  logic [CFGD_W-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_command,
    input  logic [PIX_W-1:0]  i_pixel_in,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [PIX_W-1:0]  o_pixel_out,
    output logic [ROW_W-1:0]  o_out_row,
    output logic [COL_W-1:0]  o_out_col,
    output logic              o_last_of_run,
    output logic              o_end_of_frame
);

    // Configuration registers, taken by the back end every cycle.
    t_cfg  r_cfg;
    logic  w_item_valid;
    t_item w_item;
    logic  w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= CFGW_W'(640);
            r_cfg.height <= CFGH_W'(480);
            r_cfg.win    <= WIN_W'(3);
            r_cfg.mode   <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data[CFGW_W-1:0];
                CFG_HEIGHT: r_cfg.height <= i_cfg_data[CFGH_W-1:0];
                CFG_WINDOW: r_cfg.win    <= i_cfg_data[WIN_W-1:0];
                CFG_MODE:   r_cfg.mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The front end queues and classifies beats.
    inwf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_pixel_in   (i_pixel_in),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    // The back end stores pixels and releases filtered outputs.
    inwf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_item_valid   (w_item_valid),
        .i_item         (w_item),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_out    (o_pixel_out),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

// File: hdl/inwf_front.sv
// ============================================================================
// Impulse noise window filter front end
// Accepts input beats, classifies them as pixel or flush and queues them.
// ============================================================================
module inwf_front
    import inwf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_command,
    input  logic [PIX_W-1:0] i_pixel_in,
    output logic             o_item_valid,
    output t_item            o_item,
    input  logic             i_pop
);

    localparam int PW = $clog2(Q_DEPTH);

    t_item             r_q [Q_DEPTH];
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_rp;
    logic [PW:0]       r_cnt;
    logic              w_push;
    logic              w_pop;
    t_item             w_new;

    assign o_stall      = (r_cnt == (PW+1)'(Q_DEPTH));
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rp];
    assign w_push       = i_valid && !o_stall;
    assign w_pop        = i_pop && o_item_valid;

    always_comb begin
        w_new.is_flush = i_command;
        w_new.pixel    = i_pixel_in;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(Q_DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(Q_DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: hdl/inwf_div.sv
// ============================================================================
// Impulse noise window filter divider
// Restoring divider, one quotient bit per cycle.
// ============================================================================
module inwf_div
    import inwf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_busy,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_quot,
    output logic [DIVS_W-1:0] o_rem
);

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  r_quo;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_d;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIVS_W:0]   w_t;
    logic              w_ge;

    assign w_t    = {r_rem, r_quo[DIV_W-1]};
    assign w_ge   = (w_t >= {1'b0, r_d});
    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? DIVS_W'(w_t - {1'b0, r_d}) : DIVS_W'(w_t);
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

endmodule

// File: hdl/inwf_back.sv
// ============================================================================
// Impulse noise window filter back end
// Line store, raster counters, window scan, mean and median, result register.
// ============================================================================
module inwf_back
    import inwf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_item_valid,
    input  t_item            i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [PIX_W-1:0] o_pixel_out,
    output logic [ROW_W-1:0] o_out_row,
    output logic [COL_W-1:0] o_out_col,
    output logic             o_last_of_run,
    output logic             o_end_of_frame
);

    localparam int DEPTH  = MAX_WIDTH * MAX_WINDOW;
    localparam int AW     = $clog2(DEPTH);
    localparam int WLIM   = (MAX_WIDTH < WIDTH_CAP) ? MAX_WIDTH : WIDTH_CAP;
    localparam int MW_ODD = (MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;

    function automatic logic [ROW_W-1:0] clamp_row(input logic signed [ROW_W+1:0] v,
                                                   input logic [ROW_W-1:0] hi);
        logic [ROW_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({2'b00, hi})) begin
            res = hi;
        end else begin
            res = ROW_W'(v);
        end
        return res;
    endfunction

    function automatic logic [COL_W-1:0] clamp_col(input logic signed [COL_W+1:0] v,
                                                   input logic [COL_W-1:0] hi);
        logic [COL_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({2'b00, hi})) begin
            res = hi;
        end else begin
            res = COL_W'(v);
        end
        return res;
    endfunction

    function automatic logic [AW-1:0] store_addr(input logic [WIN_W-1:0] slot,
                                                 input logic [COL_W-1:0] col);
        logic [COL_W-1:0] c;
        if (CFGH_W'(col) > CFGH_W'(MAX_WIDTH - 1)) begin
            c = COL_W'(MAX_WIDTH - 1);
        end else begin
            c = col;
        end
        return AW'(AW'(slot) * AW'(MAX_WIDTH)) + AW'(c);
    endfunction

    // Control and counters.
    t_state             r_state;
    t_state             n_state;
    logic [ROW_W-1:0]   r_in_row;
    logic [COL_W-1:0]   r_in_col;
    logic [ROW_W-1:0]   r_pend_row;
    logic [COL_W-1:0]   r_pend_col;
    logic               r_done;
    logic [2:0]         r_count;
    logic               r_eof;
    logic               r_rv;
    logic               r_rc;
    logic               r_ovalid;

    // Item and window scan.
    logic               r_is_flush;
    logic [PIX_W-1:0]   r_pix;
    logic [WIN_W-1:0]   r_dx;
    logic [WIN_W-1:0]   r_dy;
    logic [ROW_W-1:0]   r_rr;
    logic [ROW_W-1:0]   r_rr0;
    logic [WIN_W-1:0]   r_rslot;
    logic [WIN_W-1:0]   r_slot0;
    logic [2:0]         r_pass;
    logic [DIV_W-1:0]   r_sum;
    logic [DIVS_W-1:0]  r_cnt;
    logic [DIVS_W-1:0]  r_rank;
    logic [PIX_W-1:0]   r_prefix;
    logic [PIX_W-1:0]   r_center;
    logic [PIX_W-1:0]   r_val;
    logic [ROW_W-1:0]   r_res_row;
    logic [COL_W-1:0]   r_res_col;
    logic [PIX_W-1:0]   r_q;
    logic [PIX_W-1:0]   r_opix;
    logic [ROW_W-1:0]   r_orow;
    logic [COL_W-1:0]   r_ocol;
    logic               r_olast;
    logic               r_oeof;

    logic [PIX_W-1:0]   mem [DEPTH];

    // Effective configuration.
    logic [CFGW_W-1:0]  w_weff;
    logic [CFGH_W-1:0]  w_heff;
    logic [WIN_W-1:0]   w_win;
    logic [WIN_W-1:0]   w_win_m1;
    logic [1:0]         w_half;
    logic [DIVS_W-1:0]  w_n;
    logic [ROW_W-1:0]   w_h_m1;
    logic [COL_W-1:0]   w_w_m1;

    logic               w_cmp;
    logic [2:0]         w_limit;
    logic               w_go;
    logic               w_last;
    logic               w_out_free;
    logic               w_keep;
    logic               w_mean;
    logic               w_last_rd;
    logic               w_center_rd;
    logic [ROW_W-1:0]   w_rr_first;
    logic [ROW_W-1:0]   w_rr_next;
    logic [COL_W-1:0]   w_cc;
    logic [AW-1:0]      w_addr;
    logic [PIX_W-1:0]   w_hmask;
    logic [2:0]         w_bit;
    logic               w_match;
    logic               w_newbit;

    logic               w_mem_we;
    logic               w_div_start;
    logic [DIV_W-1:0]   w_div_a;
    logic [DIVS_W-1:0]  w_div_b;
    logic               w_div_busy;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_div_q;
    logic [DIVS_W-1:0]  w_div_r;

    always_comb begin
        logic [WIN_W-1:0] wt;
        logic [CFGH_W-1:0] rq;
        logic [CFGW_W-1:0] cq;
        w_weff = (i_cfg.width == '0) ? CFGW_W'(1) :
                 ((i_cfg.width > CFGW_W'(WLIM)) ? CFGW_W'(WLIM) : i_cfg.width);
        w_heff = (i_cfg.height == '0) ? CFGH_W'(1) :
                 ((i_cfg.height > CFGH_W'(MAX_HEIGHT)) ? CFGH_W'(MAX_HEIGHT) : i_cfg.height);
        wt = i_cfg.win;
        if (!wt[0]) begin
            wt = (wt == '0) ? WIN_W'(1) : wt - 1'b1;
        end
        if (wt > WIN_W'(MW_ODD)) begin
            wt = WIN_W'(MW_ODD);
        end
        w_win    = wt;
        w_win_m1 = wt - 1'b1;
        w_half   = wt[2:1];
        w_n      = DIVS_W'(DIVS_W'(wt) * DIVS_W'(wt));
        w_h_m1   = ROW_W'(w_heff - 1'b1);
        w_w_m1   = COL_W'(w_weff - 1'b1);

        rq = CFGH_W'(r_pend_row) + CFGH_W'(w_half);
        if (rq > CFGH_W'(w_h_m1)) begin
            rq = CFGH_W'(w_h_m1);
        end
        cq = CFGW_W'(r_pend_col) + CFGW_W'(w_half);
        if (cq > CFGW_W'(w_w_m1)) begin
            cq = CFGW_W'(w_w_m1);
        end
        w_cmp = r_done || (ROW_W'(rq) < r_in_row) ||
                ((ROW_W'(rq) == r_in_row) && (COL_W'(cq) < r_in_col));
    end

    assign w_limit    = r_is_flush ? 3'd1 : 3'(MAX_RES);
    assign w_go       = w_cmp && (r_count < w_limit);
    assign w_last     = r_eof || (r_count >= w_limit) || !w_cmp;
    assign w_out_free = !(r_ovalid && i_stall);
    assign w_keep     = (r_pass == '0) && (r_center != PIX_BLACK) && (r_center != PIX_WHITE);
    assign w_mean     = (r_pass == '0) && !i_cfg.mode;
    assign w_last_rd  = (r_dx == w_win_m1) && (r_dy == w_win_m1);
    assign w_center_rd = (r_dx == WIN_W'(w_half)) && (r_dy == WIN_W'(w_half));

    assign w_rr_first = clamp_row($signed({2'b00, r_pend_row}) - $signed({12'b0, w_half}),
                                  w_h_m1);
    assign w_rr_next  = clamp_row($signed({2'b00, r_pend_row}) + $signed({11'b0, r_dy})
                                  + $signed(14'd1) - $signed({12'b0, w_half}), w_h_m1);
    assign w_cc       = clamp_col($signed({2'b00, r_pend_col}) + $signed({9'b0, r_dx})
                                  - $signed({10'b0, w_half}), w_w_m1);

    assign w_addr = w_mem_we ? store_addr(WIN_W'(w_div_r), r_in_col)
                             : store_addr(r_rslot, w_cc);

    // Radix select of the median: one bit per pass, high bits first.
    assign w_bit    = 3'd7 - r_pass;
    assign w_hmask  = ~(8'hFF >> r_pass);
    assign w_match  = (((r_q ^ r_prefix) & w_hmask) == '0) && !r_q[w_bit];
    assign w_newbit = !(r_rank < r_cnt);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (r_is_flush) n_state = S_CHECK;
                else if (r_done) n_state = S_IDLE;
                else n_state = S_WMOD;
            end
            S_WMOD: begin
                if (w_div_done) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = w_go ? S_RMOD : S_IDLE;
            end
            S_RMOD: begin
                if (w_div_done) n_state = S_RD;
            end
            S_RD: begin
                if (w_last_rd) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_keep || (r_pass == 3'd7 && !w_mean)) n_state = S_ADV;
                else if (w_mean) n_state = S_MDIV;
                else n_state = S_RD;
            end
            S_MDIV: begin
                if (w_div_done) n_state = S_ADV;
            end
            S_ADV: begin
                n_state = S_LOOK;
            end
            S_LOOK: begin
                if (w_out_free) n_state = w_last ? S_IDLE : S_CHECK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_pop       = 1'b0;
        w_mem_we    = 1'b0;
        w_div_start = 1'b0;
        w_div_a     = DIV_W'(r_in_row);
        w_div_b     = DIVS_W'(w_win);
        unique case (r_state)
            S_IDLE:   o_pop = i_item_valid;
            S_DECODE: w_div_start = !r_is_flush && !r_done;
            S_WMOD:   w_mem_we = w_div_done;
            S_CHECK: begin
                w_div_start = w_go;
                w_div_a     = DIV_W'(w_rr_first);
            end
            S_EVAL: begin
                w_div_start = w_mean && !w_keep;
                w_div_a     = r_sum;
                w_div_b     = w_n;
            end
            S_RMOD, S_RD, S_DRAIN, S_MDIV, S_ADV, S_LOOK: begin
            end
            default: begin
            end
        endcase
    end

    inwf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_div_q),
        .o_rem      (w_div_r)
    );

    // Line store.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_addr] <= r_pix;
        end
        r_q <= mem[w_addr];
    end

    // Payload side of the datapath.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_is_flush <= i_item.is_flush;
            r_pix      <= i_item.pixel;
        end
        if (r_rv) begin
            r_sum <= r_sum + DIV_W'(r_q);
            r_cnt <= r_cnt + DIVS_W'(w_match);
            if (r_rc) r_center <= r_q;
        end
        case (r_state)
            S_CHECK: begin
                r_rr0    <= w_rr_first;
                r_pass   <= '0;
                r_prefix <= '0;
                r_rank   <= w_n >> 1;
            end
            S_RMOD: begin
                r_rr    <= r_rr0;
                r_rslot <= WIN_W'(w_div_r);
                r_slot0 <= WIN_W'(w_div_r);
                r_dx    <= '0;
                r_dy    <= '0;
                r_sum   <= '0;
                r_cnt   <= '0;
            end
            S_RD: begin
                if (r_dx == w_win_m1) begin
                    r_dx <= '0;
                    r_dy <= r_dy + 1'b1;
                    if (w_rr_next != r_rr) begin
                        r_rr    <= w_rr_next;
                        r_rslot <= (r_rslot == w_win_m1) ? '0 : r_rslot + 1'b1;
                    end
                end else begin
                    r_dx <= r_dx + 1'b1;
                end
            end
            S_EVAL: begin
                if (w_keep) begin
                    r_val <= r_center;
                end else if (!w_mean) begin
                    r_prefix <= r_prefix | (PIX_W'(w_newbit) << w_bit);
                    r_val    <= r_prefix | (PIX_W'(w_newbit) << w_bit);
                    if (w_newbit) r_rank <= r_rank - r_cnt;
                    r_pass  <= r_pass + 1'b1;
                    r_rr    <= r_rr0;
                    r_rslot <= r_slot0;
                    r_dx    <= '0;
                    r_dy    <= '0;
                    r_cnt   <= '0;
                end
            end
            S_MDIV: begin
                if (w_div_done) r_val <= PIX_W'(w_div_q);
            end
            S_ADV: begin
                r_res_row <= r_pend_row;
                r_res_col <= r_pend_col;
            end
            default: begin
            end
        endcase
        if (r_state == S_LOOK && w_out_free) begin
            r_opix  <= r_val;
            r_orow  <= r_res_row;
            r_ocol  <= r_res_col;
            r_olast <= w_last;
            r_oeof  <= r_eof;
        end
    end

    // Control side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_pend_row <= '0;
            r_pend_col <= '0;
            r_done     <= 1'b0;
            r_count    <= '0;
            r_eof      <= 1'b0;
            r_rv       <= 1'b0;
            r_rc       <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rv    <= (r_state == S_RD);
            r_rc    <= (r_state == S_RD) && w_center_rd;
            if (r_state == S_DECODE) begin
                r_count <= '0;
            end
            if (w_mem_we) begin
                if (CFGW_W'(r_in_col) + 1'b1 >= w_weff) begin
                    r_in_col <= '0;
                    if (r_in_row >= w_h_m1) r_done <= 1'b1;
                    else r_in_row <= r_in_row + 1'b1;
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
            end
            if (r_state == S_ADV) begin
                r_count <= r_count + 1'b1;
                r_eof   <= 1'b0;
                if (CFGW_W'(r_pend_col) + 1'b1 >= w_weff) begin
                    r_pend_col <= '0;
                    if (r_pend_row >= w_h_m1) begin
                        r_eof      <= 1'b1;
                        r_pend_row <= '0;
                        r_in_row   <= '0;
                        r_in_col   <= '0;
                        r_done     <= 1'b0;
                    end else begin
                        r_pend_row <= r_pend_row + 1'b1;
                    end
                end else begin
                    r_pend_col <= r_pend_col + 1'b1;
                end
            end
            if (r_state == S_LOOK && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_pixel_out    = r_opix;
    assign o_out_row      = r_orow;
    assign o_out_col      = r_ocol;
    assign o_last_of_run  = r_olast;
    assign o_end_of_frame = r_oeof;

`ifndef NO_ASSERTIONS
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(MAX_RES))
        else $error("release count above cap");
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_frame) |-> o_last_of_run)
        else $error("frame end not marked as last of run");
    a_read_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rv |-> $past(r_state == S_RD))
        else $error("window read data without a read");
`endif

endmodule
